### src/fpds_pkg.sv
// Shared constants and types of the five-point diffusion stencil unit.
package fpds_pkg;

    localparam int FPDS_MAX_WIDTH   = 1024;
    localparam int FPDS_SAMPLE_BITS = 32;
    localparam int FPDS_FIFO_DEPTH  = 16;

    localparam int GRID_WIDTH_W  = 11;
    localparam int GRID_HEIGHT_W = 16;
    localparam int COEF_W        = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int FRAC_BITS     = 16;

    localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST  = GRID_WIDTH_W'(1024);
    localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST = GRID_HEIGHT_W'(256);
    localparam logic [GRID_HEIGHT_W-1:0] MIN_HEIGHT      = GRID_HEIGHT_W'(3);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_COEF_X      = 2'd2,
        REG_COEF_Z      = 2'd3
    } t_reg_idx;

    // Result slots written into the output queue in the same cycle.
    typedef struct packed {
        logic second;
        logic first;
    } t_push;

endpackage

### src/fpds_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fpds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/fpds_result_fifo.sv
// Output queue of result words, taking up to two words per cycle.
module fpds_result_fifo #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fpds_pkg::t_push      i_push,
    input  logic [WIDTH-1:0]     i_data0,
    input  logic [WIDTH-1:0]     i_data1,
    output logic                 o_valid,
    output logic [WIDTH-1:0]     o_data,
    input  logic                 i_ready
);
    import fpds_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_pop;
    logic [CNT_W-1:0] w_push_cnt;

    assign w_pop      = o_valid && i_ready;
    assign w_push_cnt = CNT_W'(i_push.first) + CNT_W'(i_push.second);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(w_push_cnt);
        n_rd_ptr = r_rd_ptr + PTR_W'(w_pop);
        n_count  = r_count + w_push_cnt - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push.second) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_data1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Second slot is only ever filled together with the first.
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.second |-> i_push.first)
        else $error("second result word pushed without the first");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) + 32'(w_push_cnt) - 32'(w_pop)) <= DEPTH)
        else $error("result queue overflow");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_cnt == '0 && !w_pop) |=> r_count == $past(r_count))
        else $error("queue fill changed without push or pop");

endmodule

### src/five_point_diffusion_stencil_unit.sv
// Five-point Laplacian diffusion stencil over a raster-streamed grid.
// Pipeline: an accepted item passes the registered stages into the output queue, then on to
//   m_axis; results lag the input stream by one grid row.
// Throughput: one item per cycle while s_axis_tready is high, set by the single line-store
//   read port and the prefetch of the next column; last-row items give two words each.
// Reset (synchronous, active low) clears positions, pipeline and output queue; line stores
//   are not cleared. Input is held off in the cycle after reset and after any register write.
module five_point_diffusion_stencil_unit #(
    parameter int MAX_WIDTH   = fpds_pkg::FPDS_MAX_WIDTH,
    parameter int SAMPLE_BITS = fpds_pkg::FPDS_SAMPLE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // s_axis_tdata: source_sample, accum_sample
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // m_axis_tdata: updated_value
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,
    output logic                                  m_axis_tlast,
    input  logic                                  i_cfg_we,
    input  logic [fpds_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [fpds_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import fpds_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int WW    = (CW > GRID_WIDTH_W) ? CW : GRID_WIDTH_W;
    localparam int DW    = SB + 2;
    localparam int PW    = DW + COEF_W + 1;
    localparam int RW    = PW - FRAC_BITS;
    localparam int SW    = RW + 2;
    localparam int OUT_W = ((SB + 7) / 8) * 8;
    localparam int QW    = SB + 1;
    localparam int RVW   = $clog2(FPDS_FIFO_DEPTH + 1);

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-SB+1){1'b1}}, {(SB-1){1'b0}}};
    localparam logic signed [PW-1:0] HALF_LSB = PW'(1) <<< (FRAC_BITS - 1);

    // configuration
    logic [GRID_WIDTH_W-1:0]  r_grid_width;
    logic [GRID_HEIGHT_W-1:0] r_grid_height;
    logic [COEF_W-1:0]        r_coef_x;
    logic [COEF_W-1:0]        r_coef_z;
    logic                     r_cfg_hold;
    logic                     r_warm;

    // position and credit
    logic [AW-1:0]            r_col;
    logic [GRID_HEIGHT_W-1:0] r_row;
    logic [RVW-1:0]           r_resv;
    logic signed [SB-1:0]     r_prev_mid;

    logic [WW-1:0]            w_width_ext;
    logic [WW-1:0]            w_width_eff;
    logic [AW-1:0]            w_col_last;
    logic [GRID_HEIGHT_W-1:0] w_row_last;
    logic [AW-1:0]            w_col;
    logic [AW-1:0]            w_col_next;
    logic                     w_row_end;
    logic                     w_last_row;
    logic                     w_first;
    logic                     w_inner;
    logic                     w_accept;
    logic                     w_pop;
    logic [RVW-1:0]           w_item_words;

    logic signed [SB-1:0]     w_src;
    logic signed [SB-1:0]     w_acc;

    // line store: {older source, middle source, middle accumulator}
    logic [AW-1:0]            w_raddr;
    logic [3*SB-1:0]          w_rdata;
    logic [3*SB-1:0]          w_wdata;
    logic signed [SB-1:0]     w_rd_old;
    logic signed [SB-1:0]     w_rd_mid;
    logic signed [SB-1:0]     w_rd_acc;

    // stage 1
    logic                     r_s1_vld;
    logic                     r_s1_first, r_s1_last_row, r_s1_inner;
    logic signed [SB-1:0]     r_s1_ctr, r_s1_old_c, r_s1_old_cm1, r_s1_src;
    logic signed [SB-1:0]     r_s1_acc_mid, r_s1_acc_in;
    logic signed [DW-1:0]     w_dx, w_dz;

    // stage 2
    logic                     r_s2_vld;
    logic                     r_s2_first, r_s2_last_row, r_s2_inner;
    logic signed [DW-1:0]     r_s2_dx, r_s2_dz;
    logic signed [SB-1:0]     r_s2_acc_mid, r_s2_acc_in;
    logic signed [PW-1:0]     w_px, w_pz;

    // stage 3
    logic                     r_s3_vld;
    logic                     r_s3_first, r_s3_last_row, r_s3_inner;
    logic signed [PW-1:0]     r_s3_px, r_s3_pz;
    logic signed [SB-1:0]     r_s3_acc_mid, r_s3_acc_in;
    logic signed [PW-1:0]     w_px_rnd, w_pz_rnd;

    // stage 4
    logic                     r_s4_vld;
    logic                     r_s4_first, r_s4_last_row, r_s4_inner;
    logic signed [RW-1:0]     r_s4_rx, r_s4_rz;
    logic signed [SB-1:0]     r_s4_acc_mid, r_s4_acc_in;
    logic signed [SW-1:0]     w_sum;
    logic [SB-1:0]            w_res;

    t_push                    w_push;
    logic [QW-1:0]            w_q_data0, w_q_data1;
    logic [QW-1:0]            w_q_out;
    logic [RVW-1:0]           w_push_cnt;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
            r_coef_x      <= '0;
            r_coef_z      <= '0;
            r_cfg_hold    <= 1'b0;
            r_warm        <= 1'b0;
        end else begin
            r_cfg_hold <= i_cfg_we;
            r_warm     <= 1'b1;
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_GRID_WIDTH:  r_grid_width  <= i_cfg_wdata[GRID_WIDTH_W-1:0];
                    REG_GRID_HEIGHT: r_grid_height <= i_cfg_wdata[GRID_HEIGHT_W-1:0];
                    REG_COEF_X:      r_coef_x      <= i_cfg_wdata[COEF_W-1:0];
                    REG_COEF_Z:      r_coef_z      <= i_cfg_wdata[COEF_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- position decode ----------------
    always_comb begin
        w_width_ext = WW'(r_grid_width);
        if (w_width_ext < WW'(3)) begin
            w_width_eff = WW'(3);
        end else if (w_width_ext > WW'(MAX_WIDTH)) begin
            w_width_eff = WW'(MAX_WIDTH);
        end else begin
            w_width_eff = w_width_ext;
        end
        w_col_last = AW'(w_width_eff - WW'(1));
        w_row_last = ((r_grid_height < MIN_HEIGHT) ? MIN_HEIGHT : r_grid_height)
                     - GRID_HEIGHT_W'(1);
        // clamp a column left past the row end by a width change
        w_col      = (r_col >= w_col_last) ? w_col_last : r_col;
        w_row_end  = (w_col == w_col_last);
        w_col_next = w_row_end ? '0 : w_col + AW'(1);
        w_last_row = (r_row >= w_row_last);
        w_first    = (r_row != '0);
        w_inner    = (r_row >= GRID_HEIGHT_W'(2)) && (r_row <= w_row_last)
                     && (w_col != '0) && !w_row_end;
        w_item_words = RVW'(w_first) + RVW'(w_last_row);
    end

    assign w_src = s_axis_tdata[SB-1:0];
    assign w_acc = s_axis_tdata[2*SB-1:SB];

    assign s_axis_tready = r_warm && !r_cfg_hold
                           && (r_resv <= RVW'(FPDS_FIFO_DEPTH - 2));
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_pop    = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_resv <= '0;
        end else begin
            r_resv <= r_resv + (w_accept ? w_item_words : '0) - RVW'(w_pop);
            if (w_accept) begin
                r_col <= w_col_next;
                if (w_row_end) begin
                    r_row <= w_last_row ? '0 : r_row + GRID_HEIGHT_W'(1);
                end
            end
        end
    end

    // ---------------- line store ----------------
    // Read one column ahead on accept so the entry of the next item and the right
    // neighbour of this item are both on the read port when needed.
    assign w_raddr = w_accept ? w_col_next : w_col;
    assign w_wdata = {w_rd_mid, w_src, w_acc};

    assign w_rd_old = w_rdata[3*SB-1:2*SB];
    assign w_rd_mid = w_rdata[2*SB-1:SB];
    assign w_rd_acc = w_rdata[SB-1:0];

    fpds_ram #(
        .WIDTH (3 * SB),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_col),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- pipeline ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prev_mid    <= w_rd_mid;
            r_s1_first    <= w_first;
            r_s1_last_row <= w_last_row;
            r_s1_inner    <= w_inner;
            r_s1_ctr      <= w_rd_mid;
            r_s1_old_c    <= w_rd_old;
            r_s1_old_cm1  <= r_prev_mid;
            r_s1_src      <= w_src;
            r_s1_acc_mid  <= w_rd_acc;
            r_s1_acc_in   <= w_acc;
        end
    end

    // right neighbour arrives on the read port in the cycle after accept
    assign w_dx = DW'(w_rd_mid) + DW'(r_s1_old_cm1) - (DW'(r_s1_ctr) <<< 1);
    assign w_dz = DW'(r_s1_src) + DW'(r_s1_old_c)   - (DW'(r_s1_ctr) <<< 1);

    always_ff @(posedge i_clk) begin
        r_s2_first    <= r_s1_first;
        r_s2_last_row <= r_s1_last_row;
        r_s2_inner    <= r_s1_inner;
        r_s2_dx       <= w_dx;
        r_s2_dz       <= w_dz;
        r_s2_acc_mid  <= r_s1_acc_mid;
        r_s2_acc_in   <= r_s1_acc_in;
    end

    assign w_px = PW'(r_s2_dx) * PW'($signed({1'b0, r_coef_x}));
    assign w_pz = PW'(r_s2_dz) * PW'($signed({1'b0, r_coef_z}));

    always_ff @(posedge i_clk) begin
        r_s3_first    <= r_s2_first;
        r_s3_last_row <= r_s2_last_row;
        r_s3_inner    <= r_s2_inner;
        r_s3_px       <= w_px;
        r_s3_pz       <= w_pz;
        r_s3_acc_mid  <= r_s2_acc_mid;
        r_s3_acc_in   <= r_s2_acc_in;
    end

    // round to nearest, ties up: add half an LSB and drop the fraction
    assign w_px_rnd = r_s3_px + HALF_LSB;
    assign w_pz_rnd = r_s3_pz + HALF_LSB;

    always_ff @(posedge i_clk) begin
        r_s4_first    <= r_s3_first;
        r_s4_last_row <= r_s3_last_row;
        r_s4_inner    <= r_s3_inner;
        r_s4_rx       <= w_px_rnd[PW-1:FRAC_BITS];
        r_s4_rz       <= w_pz_rnd[PW-1:FRAC_BITS];
        r_s4_acc_mid  <= r_s3_acc_mid;
        r_s4_acc_in   <= r_s3_acc_in;
    end

    always_comb begin
        w_sum = SW'(r_s4_acc_mid) + SW'(r_s4_rx) + SW'(r_s4_rz);
        if (!r_s4_inner) begin
            w_res = r_s4_acc_mid;
        end else if (w_sum > SAT_HI) begin
            w_res = SAT_HI[SB-1:0];
        end else if (w_sum < SAT_LO) begin
            w_res = SAT_LO[SB-1:0];
        end else begin
            w_res = w_sum[SB-1:0];
        end
    end

    // ---------------- output queue ----------------
    always_comb begin
        w_push.first  = r_s4_vld && (r_s4_first || r_s4_last_row);
        w_push.second = r_s4_vld && r_s4_first && r_s4_last_row;
        // boundary pass-through of the last row goes after the lagged result
        w_q_data0 = r_s4_first ? {!r_s4_last_row, w_res} : {1'b1, r_s4_acc_in};
        w_q_data1 = {1'b1, r_s4_acc_in};
        w_push_cnt = RVW'(w_push.first) + RVW'(w_push.second);
    end

    fpds_result_fifo #(
        .WIDTH (QW),
        .DEPTH (FPDS_FIFO_DEPTH)
    ) u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data0 (w_q_data0),
        .i_data1 (w_q_data1),
        .o_valid (m_axis_tvalid),
        .o_data  (w_q_out),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = OUT_W'(w_q_out[SB-1:0]);
    assign m_axis_tlast = w_q_out[SB];

    // ---------------- checks ----------------
    a_resv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_resv <= RVW'(FPDS_FIFO_DEPTH))
        else $error("output reservation exceeds queue depth");

    a_push_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_cnt <= r_resv)
        else $error("result words pushed without reservation");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_row_end) |=> (r_col == '0))
        else $error("column did not wrap at row end");

    a_word_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4 (w_push_cnt == $past(w_item_words, 4)))
        else $error("pushed word count differs from count reserved at accept");

endmodule

### verif/fpds_stencil_checker.sv
// Stream checker for the diffusion stencil: predicts each result word and compares it.
`timescale 1ns / 1ps

module fpds_stencil_checker
    import fpds_pkg::*;
(
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_s_tvalid,
    input  logic                                       i_s_tready,
    // source_sample, accum_sample
    input  logic [((2*FPDS_SAMPLE_BITS+7)/8)*8-1:0]    i_s_tdata,
    input  logic                                       i_m_tvalid,
    input  logic                                       i_m_tready,
    // updated_value
    input  logic [((FPDS_SAMPLE_BITS+7)/8)*8-1:0]      i_m_tdata,
    input  logic                                       i_m_tlast,
    input  logic                                       i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]                     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                      i_cfg_wdata,
    output int                                         o_mismatches,
    output int                                         o_outstanding
);

    localparam int     SB     = FPDS_SAMPLE_BITS;
    localparam longint SAT_HI = (64'sd1 <<< (SB - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic [SB-1:0] value;
        logic          last;
    } t_result;

    t_result results_due[$];
    int      mismatch_total = 0;

    logic [GRID_WIDTH_W-1:0]  width_reg;
    logic [GRID_HEIGHT_W-1:0] height_reg;
    logic [COEF_W-1:0]        kx;
    logic [COEF_W-1:0]        kz;

    longint src_older  [FPDS_MAX_WIDTH];
    longint src_middle [FPDS_MAX_WIDTH];
    longint acc_middle [FPDS_MAX_WIDTH];
    int     col;
    int     row;

    assign o_mismatches = mismatch_total;

    // Round a Q48.16 product to a Q48.0 integer, ties toward plus infinity.
    function automatic longint round_q16(longint product);
        return (product + 64'sd32768) >>> FRAC_BITS;
    endfunction

    // Advance the stencil by one grid point and queue the words it releases.
    function automatic void step_stencil(logic [SB-1:0] src_bits, logic [SB-1:0] acc_bits);
        longint  src;
        longint  ctr;
        longint  lap_x;
        longint  lap_z;
        longint  sum;
        int      w;
        int      h;
        int      c;
        bit      bottom;
        t_result due;
        src = longint'($signed(src_bits));
        w = int'(width_reg);
        if (w < 3) w = 3;
        if (w > FPDS_MAX_WIDTH) w = FPDS_MAX_WIDTH;
        h = int'(height_reg);
        if (h < 3) h = 3;
        // A column left past the edge by a width change ends the row.
        c = (col >= w) ? w - 1 : col;
        bottom = (row >= h - 1);

        if (row > 0) begin
            sum = acc_middle[c];
            // The point one row up is interior only if its own neighbors are in the grid.
            if (row >= 2 && row <= h - 1 && c >= 1 && c + 1 < w) begin
                ctr   = src_middle[c];
                lap_x = src_middle[c+1] - 2 * ctr + src_older[c-1];
                lap_z = src - 2 * ctr + src_older[c];
                sum   = sum + round_q16(longint'(kx) * lap_x) + round_q16(longint'(kz) * lap_z);
                if (sum > SAT_HI) sum = SAT_HI;
                else if (sum < SAT_LO) sum = SAT_LO;
            end
            due.value = sum[SB-1:0];
            due.last  = !bottom;
            results_due.push_back(due);
        end
        // Bottom row points are boundary points: pass the accumulator through.
        if (bottom) begin
            due.value = acc_bits;
            due.last  = 1'b1;
            results_due.push_back(due);
        end

        src_older[c]  = src_middle[c];
        src_middle[c] = src;
        acc_middle[c] = longint'($signed(acc_bits));

        if (c + 1 >= w) begin
            col = 0;
            row = bottom ? 0 : (row + 1) % (1 << GRID_HEIGHT_W);
        end else begin
            col = c + 1;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            width_reg  = GRID_WIDTH_RST;
            height_reg = GRID_HEIGHT_RST;
            kx         = '0;
            kz         = '0;
            col        = 0;
            row        = 0;
            foreach (src_older[i]) begin
                src_older[i]  = 0;
                src_middle[i] = 0;
                acc_middle[i] = 0;
            end
            results_due.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_GRID_WIDTH:  width_reg  = i_cfg_wdata[GRID_WIDTH_W-1:0];
                    REG_GRID_HEIGHT: height_reg = i_cfg_wdata[GRID_HEIGHT_W-1:0];
                    REG_COEF_X:      kx         = i_cfg_wdata[COEF_W-1:0];
                    REG_COEF_Z:      kz         = i_cfg_wdata[COEF_W-1:0];
                    default: ;
                endcase
            end

            // Retire the output word before queueing new words; an item accepted at
            // this edge cannot have produced it.
            if (i_m_tvalid && i_m_tready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected word: updated_value %0d, last_of_item %0b",
                           $signed(i_m_tdata[SB-1:0]), i_m_tlast);
                    mismatch_total++;
                end else begin
                    want = results_due.pop_front();
                    if (i_m_tdata[SB-1:0] !== want.value) begin
                        $error("updated_value: expected %0d, got %0d",
                               $signed(want.value), $signed(i_m_tdata[SB-1:0]));
                        mismatch_total++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last_of_item: expected %0b, got %0b", want.last, i_m_tlast);
                        mismatch_total++;
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                step_stencil(i_s_tdata[SB-1:0], i_s_tdata[2*SB-1:SB]);
            end

            o_outstanding <= results_due.size();
        end
    end

endmodule

### verif/tb_five_point_diffusion_stencil_unit.sv
// Testbench top for the diffusion stencil unit: drives grids and register writes, gives the verdict.
`timescale 1ns / 1ps

module tb_five_point_diffusion_stencil_unit;

    import fpds_pkg::*;

    localparam int          SB            = FPDS_SAMPLE_BITS;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          RANDOM_ITEMS  = 150;
    localparam int          LONG_HOLD     = 300;
    localparam logic [31:0] SAMPLE_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] SAMPLE_MIN    = 32'h8000_0000;

    logic                                   i_clk         = 1'b0;
    logic                                   i_rst_n       = 1'b0;
    logic                                   s_axis_tvalid = 1'b0;
    logic                                   s_axis_tready;
    // source_sample, accum_sample
    logic [((2*SB+7)/8)*8-1:0]              s_axis_tdata  = '0;
    logic                                   m_axis_tvalid;
    logic                                   m_axis_tready = 1'b0;
    // updated_value
    logic [((SB+7)/8)*8-1:0]                m_axis_tdata;
    logic                                   m_axis_tlast;
    logic                                   i_cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0]                 i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]                  i_cfg_wdata   = '0;

    int mismatches;
    int outstanding;
    bit src_gaps   = 1'b1;
    bit sink_gaps  = 1'b1;
    bit hold_req   = 1'b0;
    int eff_width  = FPDS_MAX_WIDTH;
    int eff_height = 256;
    int sent_items = 0;

    five_point_diffusion_stencil_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    fpds_stencil_checker stencil_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tlast     (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3, 4: return r;
            default: return {{11{r[20]}}, r[20:0]};
        endcase
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;   // odd differences land on rounding ties
            3:       return 16'($urandom_range(0, 16'h0FFF));
            default: return 16'($urandom);
        endcase
    endfunction

    // Drop valid, wait for every expected word, then let the pipeline empty.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_GRID_WIDTH) begin
            eff_width = int'(value[GRID_WIDTH_W-1:0]);
            if (eff_width < 3) eff_width = 3;
            if (eff_width > FPDS_MAX_WIDTH) eff_width = FPDS_MAX_WIDTH;
        end else if (idx == REG_GRID_HEIGHT) begin
            eff_height = (value < 3) ? 3 : int'(value);
        end
    endtask

    task automatic set_grid(logic [15:0] width, logic [15:0] height,
                            logic [15:0] cx, logic [15:0] cz);
        drain_results();
        write_reg(REG_GRID_WIDTH, width);
        write_reg(REG_GRID_HEIGHT, height);
        write_reg(REG_COEF_X, cx);
        write_reg(REG_COEF_Z, cz);
    endtask

    task automatic send_point(logic [31:0] src, logic [31:0] acc);
        @(negedge i_clk);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {acc, src};
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
    endtask

    task automatic send_points(int count);
        for (int i = 0; i < count; i++) begin
            send_point(pick_sample(), pick_sample());
        end
    endtask

    // Output side: random stall bursts, plus one long hold-off on request.
    initial begin : sink
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("five_point_diffusion_stencil_unit verification failed");
        $finish;
    end

    initial begin : stimulus
        int random_goal;
        int mode;
        int w_val;
        int h_val;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Saturation at both rails: point (1,1) overflows high, point (2,1) low.
        set_grid(16'd3, 16'd4, 16'hFFFF, 16'hFFFF);
        send_point(32'd0, 32'd0);
        send_point(SAMPLE_MAX, 32'd0);
        send_point(32'd0, 32'd0);
        send_point(SAMPLE_MAX, 32'd0);
        send_point(SAMPLE_MIN, SAMPLE_MAX);
        send_point(SAMPLE_MAX, 32'd0);
        send_point(SAMPLE_MIN, 32'd0);
        send_point(SAMPLE_MAX, SAMPLE_MIN);
        send_point(SAMPLE_MIN, 32'd0);
        send_point(32'd0, SAMPLE_MAX);
        send_point(SAMPLE_MIN, SAMPLE_MIN);
        send_point(32'd0, 32'd0);

        // Rounding ties of both signs: +1.5 goes to 2, -1.5 goes to -1.
        set_grid(16'd3, 16'd3, 16'h8000, 16'h8000);
        send_point(32'd0, 32'd0);
        send_point(32'd1, 32'd0);
        send_point(32'd0, 32'd0);
        send_point(32'd3, 32'd0);
        send_point(32'd0, 32'd7);
        send_point(32'd0, 32'd0);
        send_point(32'd0, 32'd0);
        send_point(32'hFFFF_FFFC, 32'd0);
        send_point(32'd0, 32'd0);

        // Narrow the width in mid-row: the column past the new edge ends the row.
        set_grid(16'd4, 16'd4, pick_coef(), pick_coef());
        send_points(11);
        drain_results();
        write_reg(REG_GRID_WIDTH, 16'd3);
        send_points(4);

        // Tallest grid, cut short by lowering the height below the current row.
        set_grid(16'd2, 16'hFFFF, pick_coef(), pick_coef());
        send_points(10 * eff_width);
        drain_results();
        write_reg(REG_GRID_HEIGHT, 16'd1);
        send_points(eff_width);

        // Width register above the limit clamps; shrink after the first row.
        set_grid(16'd2047, 16'd5, pick_coef(), pick_coef());
        send_points(eff_width);
        drain_results();
        write_reg(REG_GRID_WIDTH, 16'd5);
        // Stall the output for a long stretch while the rest of the grid streams in.
        hold_req = 1'b1;
        send_points(4 * eff_width);

        random_goal = sent_items + RANDOM_ITEMS;
        while (sent_items < random_goal) begin
            mode      = $urandom_range(0, 3);
            src_gaps  = mode[0];
            sink_gaps = mode[1];
            w_val = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
            h_val = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
            set_grid(16'(w_val), 16'(h_val), pick_coef(), pick_coef());
            // Sometimes run two grids back to back to cross the row wrap.
            send_points(eff_width * eff_height * $urandom_range(1, 2));
        end

        // Closing stretch at full rate on both sides.
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        for (int g = 0; g < 3; g++) begin
            set_grid(16'($urandom_range(3, 16)), 16'($urandom_range(3, 8)),
                     pick_coef(), pick_coef());
            send_points(eff_width * eff_height);
        end

        drain_results();
        if (mismatches == 0) begin
            $display("five_point_diffusion_stencil_unit verification clean");
        end else begin
            $display("five_point_diffusion_stencil_unit verification failed");
        end
        $finish;
    end

endmodule
